// ----- rtl/dtt_pkg.sv -----
// Shared types, codes and microcode program of the deferred removal timer table.
package dtt_pkg;

  // Fixed field widths
  localparam int unsigned HandleW = 16;
  localparam int unsigned DelayW  = 20;
  localparam int unsigned PeriodW = 10;
  localparam int unsigned StatusW = 2;

  // Parameter defaults
  localparam int unsigned DefSlots      = 32;
  localparam int unsigned DefHandleBits = 16;
  localparam int unsigned DefTickBits   = 32;

  // Configuration
  localparam int unsigned AddrW          = 2;
  localparam int unsigned DataW          = 32;
  localparam logic [AddrW-1:0] RegTickPeriod = 2'd0;
  localparam logic [PeriodW-1:0] PeriodReset = 10'd2;

  // Result status codes
  localparam logic [StatusW-1:0] StScheduled = 2'd0;
  localparam logic [StatusW-1:0] StFull      = 2'd1;
  localparam logic [StatusW-1:0] StExpired   = 2'd2;
  localparam logic [StatusW-1:0] StNone      = 2'd3;

  // Operation codes
  localparam logic OpTick     = 1'b0;
  localparam logic OpSchedule = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [HandleW-1:0] handle;
    logic [DelayW-1:0]  delay_ms;
  } in_item_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [HandleW-1:0] handle_out;
    logic               last;
  } out_item_t;

  // Microcode step addresses
  localparam int unsigned UpcW = 4;
  typedef logic [UpcW-1:0] upc_t;

  localparam upc_t UpcIdle     = 4'd0;
  localparam upc_t UpcDispatch = 4'd1;
  localparam upc_t UpcSchStart = 4'd2;
  localparam upc_t UpcSchWait  = 4'd3;
  localparam upc_t UpcSchWrite = 4'd4;
  localparam upc_t UpcSchFull  = 4'd5;
  localparam upc_t UpcTick     = 4'd6;
  localparam upc_t UpcScanIss  = 4'd7;
  localparam upc_t UpcScanEval = 4'd8;
  localparam upc_t UpcFlush    = 4'd9;

  // Jump conditions: jump when true, else fall through to the next step
  typedef enum logic [2:0] {
    CondAlways   = 3'd0,
    CondNoIn     = 3'd1,
    CondOpTick   = 3'd2,
    CondFull     = 3'd3,
    CondDivBusy  = 3'd4,
    CondScanMore = 3'd5
  } cond_e;

  // Output register loads
  typedef enum logic [2:0] {
    PushNone  = 3'd0,
    PushSched = 3'd1,
    PushFull  = 3'd2,
    PushScan  = 3'd3,
    PushFlush = 3'd4
  } push_e;

  typedef struct packed {
    cond_e cond;
    upc_t  jmp;
    logic  take_in;
    logic  div_start;
    logic  sch_write;
    logic  tick_inc;
    logic  scan_init;
    logic  scan_step;
    push_e push;
  } ctrl_word_t;

  typedef struct packed {
    logic in_valid;
    logic op_tick;
    logic full;
    logic div_busy;
    logic scan_more;
  } cond_flags_t;

  // Control store
  function automatic ctrl_word_t ucode_rom(upc_t upc);
    ctrl_word_t cw;
    cw = '{cond: CondAlways, jmp: UpcIdle, take_in: 1'b0, div_start: 1'b0,
           sch_write: 1'b0, tick_inc: 1'b0, scan_init: 1'b0, scan_step: 1'b0,
           push: PushNone};
    unique case (upc)
      UpcIdle: begin
        cw.cond    = CondNoIn;
        cw.jmp     = UpcIdle;
        cw.take_in = 1'b1;
      end
      UpcDispatch: begin
        cw.cond = CondOpTick;
        cw.jmp  = UpcTick;
      end
      UpcSchStart: begin
        cw.cond      = CondFull;
        cw.jmp       = UpcSchFull;
        cw.div_start = 1'b1;
      end
      UpcSchWait: begin
        cw.cond = CondDivBusy;
        cw.jmp  = UpcSchWait;
      end
      UpcSchWrite: begin
        cw.sch_write = 1'b1;
        cw.push      = PushSched;
      end
      UpcSchFull: begin
        cw.push = PushFull;
      end
      UpcTick: begin
        cw.cond     = CondOpTick;
        cw.jmp      = UpcScanIss;
        cw.tick_inc = 1'b1;
      end
      UpcScanIss: begin
        cw.cond      = CondOpTick;
        cw.jmp       = UpcScanEval;
        cw.scan_init = 1'b1;
      end
      UpcScanEval: begin
        cw.cond      = CondScanMore;
        cw.jmp       = UpcScanEval;
        cw.scan_step = 1'b1;
        cw.push      = PushScan;
      end
      UpcFlush: begin
        cw.push = PushFlush;
      end
      default: begin
        cw.jmp = UpcIdle;
      end
    endcase
    return cw;
  endfunction

endpackage

// ----- rtl/dtt_div.sv -----
// Restoring divider, one quotient bit per cycle, for delay to tick conversion.
module dtt_div import dtt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DelayW-1:0]  dividend_i,
  input  logic [PeriodW-1:0] divisor_i,
  output logic               busy_o,
  output logic [DelayW-1:0]  quotient_o
);

  localparam int unsigned CntW = $clog2(DelayW + 1);

  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [PeriodW-1:0] rem_q, rem_d;
  logic [DelayW-1:0]  quo_q, quo_d;
  logic [PeriodW-1:0] dvs_q, dvs_d;
  logic [PeriodW:0]   shifted;
  logic               ge;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign shifted = {rem_q, quo_q[DelayW-1]};
  assign ge      = shifted >= {1'b0, dvs_q};

  always_comb begin
    cnt_d = cnt_q;
    rem_d = rem_q;
    quo_d = quo_q;
    dvs_d = dvs_q;
    if (start_i) begin
      cnt_d = CntW'(DelayW);
      rem_d = '0;
      quo_d = dividend_i;
      // A zero period counts as one
      dvs_d = (divisor_i == '0) ? PeriodW'(1) : divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - CntW'(1);
      rem_d = ge ? PeriodW'(shifted - {1'b0, dvs_q}) : shifted[PeriodW-1:0];
      quo_d = {quo_q[DelayW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = cnt_q != '0;
  assign quotient_o = quo_q;

endmodule

// ----- rtl/dtt_useq.sv -----
// Microcode sequencer: step counter, control store lookup and conditional jumps.
module dtt_useq import dtt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cond_flags_t flags_i,
  input  logic        stall_i,
  output ctrl_word_t  cw_o
);

  upc_t       upc_q, upc_d;
  ctrl_word_t cw;
  logic       taken;

  assign cw = ucode_rom(upc_q);

  // Condition select
  always_comb begin
    case (cw.cond)
      CondAlways:   taken = 1'b1;
      CondNoIn:     taken = !flags_i.in_valid;
      CondOpTick:   taken = flags_i.op_tick;
      CondFull:     taken = flags_i.full;
      CondDivBusy:  taken = flags_i.div_busy;
      CondScanMore: taken = flags_i.scan_more;
      default:      taken = 1'b1;
    endcase
  end

  // Next step: hold on stall, jump when taken, else fall through
  always_comb begin
    if (stall_i) begin
      upc_d = upc_q;
    end else if (taken) begin
      upc_d = cw.jmp;
    end else begin
      upc_d = upc_q + upc_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= UpcIdle;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign cw_o = cw;

endmodule

// ----- rtl/deferred_removal_timer_table_unit.sv -----
// Top level: slot table, tick counter, output register and configuration port.
//
// Deferred removal timer table. A schedule item (operation 1) stores its handle
// in the lowest free slot with a deadline of the current tick plus
// delay_ms / tick_period_ms and returns one result: scheduled, or full when no
// slot is free. A tick item (operation 0) advances the tick counter, then scans
// the slots in index order and returns one expired result per slot whose
// deadline has been reached, freeing it, or a single none result; last marks
// the final result of each item. Items are taken one at a time, under control
// of a microcoded sequencer. A schedule's duration is set by the 20-step
// bit-serial divider and a tick's by the one-slot-per-cycle scan of the slot
// memory; both are held while the output side stalls. The input is ready
// again as soon as the final result is in the output register. There is no
// clearing pass after reset.
module deferred_removal_timer_table_unit import dtt_pkg::*; #(
  parameter int unsigned SLOTS       = DefSlots,
  parameter int unsigned HANDLE_BITS = DefHandleBits,
  parameter int unsigned TICK_BITS   = DefTickBits
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // Input channel
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_item_t         in_item_i,
  // Output channel
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_item_t        out_item_o,
  // Configuration port
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOTS - 1);

  ctrl_word_t  cw;
  cond_flags_t flags;
  logic        stall;
  logic        fire;

  // Configuration register
  logic [PeriodW-1:0] period_q;

  // Latched item
  logic               op_q;
  logic [HandleW-1:0] handle_q;
  logic [DelayW-1:0]  delay_q;

  // Table state
  logic [SLOTS-1:0]       valid_q;
  logic [TICK_BITS-1:0]   tick_q;
  logic [HANDLE_BITS-1:0] hdl_mem [SLOTS];
  logic [TICK_BITS-1:0]   dl_mem  [SLOTS];
  logic [HANDLE_BITS-1:0] rd_hdl_q;
  logic [TICK_BITS-1:0]   rd_dl_q;

  // Scan state
  logic [IdxW-1:0]        ev_idx_q;
  logic [IdxW-1:0]        rd_addr;
  logic                   rd_en;
  logic                   pend_valid_q;
  logic [HANDLE_BITS-1:0] pend_hdl_q;
  logic [TICK_BITS-1:0]   diff;
  logic                   expired;

  // Free slot search
  logic [IdxW-1:0] free_idx;
  logic            any_free;

  // Divider
  logic              div_busy;
  logic [DelayW-1:0] quotient;

  // Output register
  logic      out_valid_q;
  out_item_t out_q;
  logic      push_req;
  out_item_t push_item;

  dtt_useq u_useq (
    .clk_i,
    .rst_ni,
    .flags_i (flags),
    .stall_i (stall),
    .cw_o    (cw)
  );

  dtt_div u_div (
    .clk_i,
    .rst_ni,
    .start_i    (cw.div_start),
    .dividend_i (delay_q),
    .divisor_i  (period_q),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  // Configuration writes and reads
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PeriodReset;
    end else if (psel && penable && pwrite && pready && paddr == RegTickPeriod) begin
      period_q <= pwdata[PeriodW-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == RegTickPeriod) ? DataW'(period_q) : '0;

  // Input transfer
  assign in_ready_o = cw.take_in;

  always_ff @(posedge clk_i) begin
    if (in_valid_i && cw.take_in) begin
      op_q     <= in_item_i.operation;
      handle_q <= in_item_i.handle;
      delay_q  <= in_item_i.delay_ms;
    end
  end

  // Lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx = IdxW'(i);
      end
    end
  end

  assign any_free = !(&valid_q);

  // Expiry test on the slot held in the registered read port
  assign diff    = tick_q - rd_dl_q;
  assign expired = valid_q[ev_idx_q] && !diff[TICK_BITS-1];

  // Result offered to the output register this step
  always_comb begin
    push_req  = 1'b0;
    push_item = '{status: StNone, handle_out: '0, last: 1'b1};
    case (cw.push)
      PushSched: begin
        push_req         = 1'b1;
        push_item.status = StScheduled;
      end
      PushFull: begin
        push_req         = 1'b1;
        push_item.status = StFull;
      end
      PushScan: begin
        push_req             = expired && pend_valid_q;
        push_item.status     = StExpired;
        push_item.handle_out = HandleW'(pend_hdl_q);
        push_item.last       = 1'b0;
      end
      PushFlush: begin
        push_req = 1'b1;
        if (pend_valid_q) begin
          push_item.status     = StExpired;
          push_item.handle_out = HandleW'(pend_hdl_q);
        end
      end
      default: begin
        push_req = 1'b0;
      end
    endcase
  end

  assign stall = push_req && out_valid_q && !out_ready_i;
  assign fire  = !stall;

  // Sequencer condition flags
  assign flags = '{in_valid:  in_valid_i,
                   op_tick:   op_q == OpTick,
                   full:      !any_free,
                   div_busy:  div_busy,
                   scan_more: ev_idx_q != LastIdx};

  // Tick counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= '0;
    end else if (cw.tick_inc && fire) begin
      tick_q <= tick_q + TICK_BITS'(1);
    end
  end

  // Valid bits: set on schedule, cleared on expiry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (fire) begin
      if (cw.sch_write) begin
        valid_q[free_idx] <= 1'b1;
      end else if (cw.scan_step && expired) begin
        valid_q[ev_idx_q] <= 1'b0;
      end
    end
  end

  // Slot memories: one write port, one registered read port
  assign rd_en   = fire && (cw.scan_init || cw.scan_step);
  assign rd_addr = (cw.scan_init || ev_idx_q == LastIdx) ? '0 : ev_idx_q + IdxW'(1);

  always_ff @(posedge clk_i) begin
    if (fire && cw.sch_write) begin
      hdl_mem[free_idx] <= HANDLE_BITS'(handle_q);
      dl_mem[free_idx]  <= tick_q + TICK_BITS'(quotient);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_hdl_q <= hdl_mem[rd_addr];
      rd_dl_q  <= dl_mem[rd_addr];
    end
  end

  // Scan index and held expired handle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_idx_q     <= '0;
      pend_valid_q <= 1'b0;
    end else if (fire) begin
      if (cw.scan_init) begin
        ev_idx_q     <= '0;
        pend_valid_q <= 1'b0;
      end else if (cw.scan_step) begin
        ev_idx_q <= rd_addr;
        if (expired) begin
          pend_valid_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && cw.scan_step && expired) begin
      pend_hdl_q <= rd_hdl_q;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push_req && fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_req && fire) begin
      out_q <= push_item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
